>>> rtl/olasd_pkg.sv
// Package for the ordered list with append, search and delete.
// Holds the list depth, field widths, operation and status codes and the
// control struct that the top level hands to every list cell.
`default_nettype none
package olasd_pkg;

	localparam int DEPTH    = 16;
	localparam int VAL_W    = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_SEARCH = 2'd1,
		KIND_DELETE = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_APPENDED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		logic             capture;
		logic             shift;
		logic [VAL_W-1:0] cmp_value;
		logic [VAL_W-1:0] app_value;
	} olasd_ctl_t;

endpackage
`default_nettype wire

>>> rtl/olasd_in_if.sv
// Request channel of the ordered list: valid, ready and the operation payload.
// Depends on olasd_pkg for the field widths.
`default_nettype none
interface olasd_in_if
	import olasd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [VAL_W-1:0]  value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

>>> rtl/olasd_out_if.sv
// Response channel of the ordered list: valid, ready and the result payload.
// Depends on olasd_pkg for the field widths.
`default_nettype none
interface olasd_out_if
	import olasd_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    position;
	logic [CNT_W-1:0]    entry_count;

	modport source (output valid, output status, output position, output entry_count,
		input ready);
	modport sink (input valid, input status, input position, input entry_count,
		output ready);
endinterface
`default_nettype wire

>>> rtl/olasd_cell.sv
// One cell of the list chain: holds one entry, registers its compare result
// and takes its neighbor's entry when a delete closes the gap.
// Depends on olasd_pkg.
`default_nettype none
module olasd_cell
	import olasd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire olasd_ctl_t       ctl,
	input  wire logic             occupied,
	input  wire logic             append_we,
	input  wire logic             found_in,
	input  wire logic [VAL_W-1:0] next_entry,
	output logic                  match,
	output logic                  found_out,
	output logic [VAL_W-1:0]      entry
);

	logic [VAL_W-1:0] entry_q;
	logic             match_s1;

	assign entry     = entry_q;
	assign match     = match_s1;
	assign found_out = found_in | match_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s1 <= 1'b0;
		end else if (ctl.capture) begin
			match_s1 <= occupied & (entry_q == ctl.cmp_value);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift && found_out) begin
			entry_q <= next_entry;
		end else if (append_we) begin
			entry_q <= ctl.app_value;
		end
	end

endmodule
`default_nettype wire

>>> rtl/ordered_list_append_search_delete.sv
// Top level of the ordered list with append, search and delete.
// Depends on olasd_pkg, olasd_in_if, olasd_out_if and olasd_cell.
//
// Usage: requests arrive on req (kind, value) and each yields exactly one
// response on rsp (status, position, entry_count). A transaction takes place
// when valid and ready are both high at a rising clock edge.
// In the cycle a request is taken, every cell compares its entry with the
// value and registers the result. Once the request sits in its stage
// register and the output register is free, the first match is picked
// along the cell chain, the append or delete shift is applied and the
// response is loaded into the output register. The block takes no new
// request while an earlier one still waits in its stage register.
// A new request may be taken while an earlier response still waits on rsp.
// When the receiver stalls, the held request waits in its stage register and
// req.ready stays low until the output register frees.
// Reset clears the entry count and all valid flags; entry contents are not
// cleared, and a cell's compare result counts only while it holds an entry.
`default_nettype none
module ordered_list_append_search_delete
	import olasd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	olasd_in_if.sink   req,
	olasd_out_if.source rsp
);

	logic [CNT_W-1:0]    count_q;
	logic                valid_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [VAL_W-1:0]    value_s1;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]    position_q;
	logic [CNT_W-1:0]    entry_count_q;

	olasd_ctl_t       ctl;
	logic             take;
	logic             advance;
	logic [DEPTH-1:0] occupied;
	logic [DEPTH-1:0] append_we;
	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] first;
	logic [DEPTH:0]   found_chain;
	logic [VAL_W-1:0] entry [DEPTH];
	logic [VAL_W-1:0] next_entry [DEPTH];
	logic             any_match;
	logic             do_append;
	logic             do_delete;
	logic [CNT_W-1:0] match_pos;
	logic [STATUS_W-1:0] status_d;
	logic [CNT_W-1:0]    position_d;
	logic [CNT_W-1:0]    count_d;

	assign req.ready = !valid_s1;
	assign take      = req.valid && !valid_s1;
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.position    = position_q;
	assign rsp.entry_count = entry_count_q;

	assign found_chain[0] = 1'b0;
	assign any_match      = found_chain[DEPTH];

	assign ctl.capture   = take;
	assign ctl.shift     = do_delete;
	assign ctl.cmp_value = req.value;
	assign ctl.app_value = value_s1;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign occupied[gi]  = count_q > CNT_W'(gi);
			assign append_we[gi] = do_append && (count_q == CNT_W'(gi));
			assign first[gi]     = match[gi] & ~found_chain[gi];
			if (gi == DEPTH - 1) begin : g_last
				assign next_entry[gi] = entry[gi];
			end else begin : g_mid
				assign next_entry[gi] = entry[gi+1];
			end
			olasd_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.occupied   (occupied[gi]),
				.append_we  (append_we[gi]),
				.found_in   (found_chain[gi]),
				.next_entry (next_entry[gi]),
				.match      (match[gi]),
				.found_out  (found_chain[gi+1]),
				.entry      (entry[gi])
			);
		end
	endgenerate

	always_comb begin
		match_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i]) begin
				match_pos = match_pos | CNT_W'(i + 1);
			end
		end
	end

	always_comb begin
		do_append  = 1'b0;
		do_delete  = 1'b0;
		status_d   = ST_NOT_FOUND;
		position_d = '0;
		count_d    = count_q;
		unique case (kind_s1)
			KIND_APPEND: begin
				if (count_q >= CNT_W'(DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					status_d  = ST_APPENDED;
					do_append = advance;
					count_d   = count_q + CNT_W'(1);
				end
			end
			KIND_SEARCH, KIND_DELETE: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if (any_match) begin
					status_d   = ST_FOUND;
					position_d = match_pos;
					if (kind_s1 == KIND_DELETE) begin
						do_delete = advance;
						count_d   = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
				status_d = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1  <= req.kind;
			value_s1 <= req.value;
		end
		if (advance) begin
			status_q      <= status_d;
			position_q    <= position_d;
			entry_count_q <= count_d;
		end
	end

endmodule
`default_nettype wire
